// ----- rtl/bpc_pkg.sv -----
// shared types, constants and helpers for the button press classifier
// no dependencies
`default_nettype none

package bpc_pkg;

	localparam int CNT_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [CNT_W-1:0] DEBOUNCE_RST = CNT_W'(20);
	localparam logic [CNT_W-1:0] DOUBLE_GAP_RST = CNT_W'(250);
	localparam logic [CNT_W-1:0] LONG_RST = CNT_W'(800);

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_LONG = CFG_IDX_W'(2);

	typedef enum logic [1:0] {
		EV_NONE,
		EV_SINGLE,
		EV_DOUBLE,
		EV_LONG
	} press_event_t;

	typedef struct packed {
		logic [CNT_W-1:0] debounce_ms;
		logic [CNT_W-1:0] double_gap_ms;
		logic [CNT_W-1:0] long_ms;
	} bpc_cfg_t;

	typedef struct packed {
		logic pressed_level;
		logic second_press_wait;
		logic long_reported;
	} bpc_status_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/bpc_cfg_regs.sv -----
// configuration register file: debounce, double gap and long hold thresholds
// depends on bpc_pkg
`default_nettype none

module bpc_cfg_regs
	import bpc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CNT_W-1:0]     wr_data,
	output bpc_cfg_t                  cfg
);

	bpc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.double_gap_ms <= DOUBLE_GAP_RST;
			cfg_q.long_ms       <= LONG_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= wr_data;
				REG_DOUBLE_GAP: cfg_q.double_gap_ms <= wr_data;
				REG_LONG:       cfg_q.long_ms       <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/bpc_core.sv -----
// debounce and press classification state with its per-tick update
// depends on bpc_pkg
`default_nettype none

module bpc_core
	import bpc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  wire logic  raw,
	input  wire bpc_cfg_t cfg,
	output press_event_t ev,
	output bpc_status_t  status
);

	logic             level_q, wait_q, long_rep_q;
	logic [CNT_W-1:0] since_toggle_q, since_press_q, since_release_q;

	logic             level_d, wait_d, long_rep_d;
	logic [CNT_W-1:0] since_toggle_d, since_press_d, since_release_d;
	logic             toggle;

	always_comb begin
		since_toggle_d  = sat_inc(since_toggle_q);
		since_press_d   = sat_inc(since_press_q);
		since_release_d = sat_inc(since_release_q);
		level_d         = level_q;
		wait_d          = wait_q;
		long_rep_d      = long_rep_q;
		ev              = EV_NONE;

		toggle = (since_toggle_d > cfg.debounce_ms) && (raw != level_q);
		if (toggle) begin
			level_d        = raw;
			since_toggle_d = '0;
			long_rep_d     = 1'b0;
			if (raw) begin
				since_press_d = '0;
			end else begin
				since_release_d = '0;
				if (wait_q) begin
					ev     = EV_DOUBLE;
					wait_d = 1'b0;
				end else begin
					wait_d = 1'b1;
				end
			end
		end

		if (!level_d && wait_d && (since_release_d > cfg.double_gap_ms)) begin
			wait_d = 1'b0;
			ev     = EV_SINGLE;
		end else if (!long_rep_d && level_d && (since_press_d > cfg.long_ms)) begin
			ev         = EV_LONG;
			long_rep_d = 1'b1;
			wait_d     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q         <= 1'b0;
			wait_q          <= 1'b0;
			long_rep_q      <= 1'b0;
			since_toggle_q  <= '0;
			since_press_q   <= '0;
			since_release_q <= '0;
		end else if (step) begin
			level_q         <= level_d;
			wait_q          <= wait_d;
			long_rep_q      <= long_rep_d;
			since_toggle_q  <= since_toggle_d;
			since_press_q   <= since_press_d;
			since_release_q <= since_release_d;
		end
	end

	assign status.pressed_level     = level_q;
	assign status.second_press_wait = wait_q;
	assign status.long_reported     = long_rep_q;

endmodule

`default_nettype wire

// ----- rtl/button_press_classifier.sv -----
// top level of the button press classifier: input register, core, result register
// depends on bpc_pkg, bpc_cfg_regs and bpc_core
//
// channel | direction | handshake          | payload
// in      | in        | in_valid/in_stall   | pin_level
// out     | out       | out_valid/out_stall | press_event
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one tick per cycle while out_stall is low; ticks pass the input then the result register
// the core state advances when a tick moves from the input register to the result register
// arst_n clears state, valid flags and thresholds to their defaults at once
// a stalled result holds; the input register still takes one more tick behind it
// cfg_ready is always high; an index beyond the three registers is ignored
`default_nettype none

module button_press_classifier
	import bpc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 pin_level,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                press_event,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_data
);

	bpc_cfg_t     cfg;
	bpc_status_t  status;
	press_event_t ev;

	logic         valid_s1, pin_s1;
	logic         valid_s2;
	press_event_t event_s2;
	logic         move_s1, take_in;

	assign cfg_ready = 1'b1;

	bpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign move_s1  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !move_s1;
	assign take_in  = in_valid && !in_stall;

	bpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (move_s1),
		.raw    (pin_s1),
		.cfg    (cfg),
		.ev     (ev),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			pin_s1 <= pin_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			event_s2 <= ev;
		end
	end

	assign out_valid   = valid_s2;
	assign press_event = event_s2;

	// a double press leaves the level released with no wait pending
	a_double_released: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (event_s2 == EV_DOUBLE)) |->
		(!status.pressed_level && !status.second_press_wait))
		else $error("double press result with level not released");

	// a long press is flagged once and cancels a waiting single
	a_long_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (event_s2 == EV_LONG)) |->
		(status.pressed_level && status.long_reported && !status.second_press_wait))
		else $error("long press result without matching state");

	// the long flag only lives during a hold
	a_long_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status.long_reported |-> status.pressed_level)
		else $error("long flag set while released");

	// a tick transfer always lands in an empty or draining input register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !move_s1) |=> (valid_s1 && $stable(pin_s1)))
		else $error("held tick lost from input register");

endmodule

`default_nettype wire

// ----- tb/tb_button_press_classifier.sv -----
// self-checking testbench for button_press_classifier: tick transfers with random gaps
// and output stalls, checked against directed rows or a debounce and press predictor
// depends on bpc_pkg and the button_press_classifier rtl
module tb_button_press_classifier;
	import bpc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
	localparam bit ROW_TICK = 1'b0;
	localparam bit ROW_CFG = 1'b1;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_TICKS = 70;

	typedef struct packed {
		bit                   kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CNT_W-1:0]     value;
		logic                 pin;
		bit                   typed;
		press_event_t         want;
	} row_t;

	localparam row_t DIRECTED_ROWS [24] = '{
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b1, 1'b1, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b0, 1'b1, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b1, 1'b1, EV_NONE},
		'{ROW_CFG, REG_DEBOUNCE, 16'h0000, 1'b0, 1'b0, EV_NONE},
		'{ROW_CFG, REG_DOUBLE_GAP, 16'h0000, 1'b0, 1'b0, EV_NONE},
		'{ROW_CFG, REG_LONG, 16'h0000, 1'b0, 1'b0, EV_NONE},
		'{ROW_CFG, REG_SPARE, 16'h1234, 1'b0, 1'b0, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b1, 1'b1, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b1, 1'b1, EV_LONG},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b1, 1'b1, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b0, 1'b0, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b0, 1'b0, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b1, 1'b0, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b0, 1'b0, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b1, 1'b0, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b0, 1'b0, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b0, 1'b0, EV_NONE},
		'{ROW_CFG, REG_DEBOUNCE, 16'hFFFF, 1'b0, 1'b0, EV_NONE},
		'{ROW_CFG, REG_DOUBLE_GAP, 16'hFFFF, 1'b0, 1'b0, EV_NONE},
		'{ROW_CFG, REG_LONG, 16'hFFFF, 1'b0, 1'b0, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b1, 1'b1, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b0, 1'b1, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b1, 1'b1, EV_NONE},
		'{ROW_TICK, REG_DEBOUNCE, 16'h0000, 1'b0, 1'b1, EV_NONE}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic pin_level;
	logic out_valid;
	logic out_stall;
	logic [1:0] press_event;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0] cfg_data;

	// predictor state and thresholds
	logic [CNT_W-1:0] thr_debounce, thr_gap, thr_long;
	logic [CNT_W-1:0] cnt_toggle, cnt_press, cnt_release;
	logic dbn_level, single_wait, long_done;

	press_event_t pending_events[$];
	int mismatch_count = 0;
	int ticks_sent = 0;
	bit sender_calm = 1'b0;

	button_press_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.press_event(press_event),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic press_event_t classify_tick(input logic raw);
		press_event_t ev;
		ev = EV_NONE;
		cnt_toggle = (cnt_toggle == CNT_MAX) ? cnt_toggle : cnt_toggle + 1'b1;
		cnt_press = (cnt_press == CNT_MAX) ? cnt_press : cnt_press + 1'b1;
		cnt_release = (cnt_release == CNT_MAX) ? cnt_release : cnt_release + 1'b1;
		if (cnt_toggle > thr_debounce && raw != dbn_level) begin
			dbn_level = raw;
			cnt_toggle = '0;
			long_done = 1'b0;
			if (raw) begin
				cnt_press = '0;
			end else begin
				cnt_release = '0;
				if (single_wait) begin
					ev = EV_DOUBLE;
					single_wait = 1'b0;
				end else begin
					single_wait = 1'b1;
				end
			end
		end
		// a waiting single takes priority over a long hold
		if (!dbn_level && single_wait && cnt_release > thr_gap) begin
			single_wait = 1'b0;
			ev = EV_SINGLE;
		end else if (!long_done && dbn_level && cnt_press > thr_long) begin
			ev = EV_LONG;
			long_done = 1'b1;
			single_wait = 1'b0;
		end
		return ev;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sender_calm || r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic push_tick(input logic pin, input bit typed, input press_event_t want);
		int gap;
		press_event_t ev;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pin_level <= pin;
		do @(posedge clk); while (in_stall);
		ev = classify_tick(pin);
		pending_events.push_back(typed ? want : ev);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DEBOUNCE: thr_debounce = val;
			REG_DOUBLE_GAP: thr_gap = val;
			REG_LONG: thr_long = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic report_wrong(input int want, input int got);
		if (mismatch_count < 10)
			$display("press_event wrong at %0t: want %0d got %0d", $time, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_events.size() == 0)
				report_wrong(-1, press_event);
			else if (press_event !== pending_events[0])
				report_wrong(pending_events.pop_front(), press_event);
			else
				void'(pending_events.pop_front());
		end
	end

	// receiver: random stalls, calm stretches and long hold-offs that back up the input
	initial begin
		int hold_left, calm_left, stall_left, next_hold_at, r;
		hold_left = 0;
		calm_left = 0;
		stall_left = 0;
		next_hold_at = 150;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (ticks_sent >= next_hold_at) begin
				hold_left = 64;
				next_hold_at += 250;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (calm_left > 0) begin
				calm_left--;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3)
					calm_left = $urandom_range(30, 80);
				else if (r < 6)
					stall_left = $urandom_range(10, 40);
				else if (r < 30)
					stall_left = $urandom_range(1, 3);
				out_stall <= (stall_left > 0);
			end
		end
	end

	initial begin
		#3000000;
		$display("button_press_classifier: mismatch");
		$finish;
	end

	initial begin
		int db, gap, lng, db_c, gap_c, long_c, k, run_len, sent;
		logic level;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pin_level = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		thr_debounce = DEBOUNCE_RST;
		thr_gap = DOUBLE_GAP_RST;
		thr_long = LONG_RST;
		cnt_toggle = '0;
		cnt_press = '0;
		cnt_release = '0;
		dbn_level = 1'b0;
		single_wait = 1'b0;
		long_done = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].kind == ROW_CFG)
				write_reg(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].value);
			else
				push_tick(DIRECTED_ROWS[r].pin, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin
					db = 0; gap = 4; lng = 10;
				end
				1: begin
					db = $urandom_range(1, 3); gap = 65535; lng = $urandom_range(5, 25);
				end
				2: begin
					db = $urandom_range(0, 4); gap = $urandom_range(0, 12); lng = 65535;
				end
				3: begin
					db = 12; gap = 40; lng = 60;
				end
				default: begin
					db = $urandom_range(0, 5); gap = $urandom_range(0, 20);
					lng = $urandom_range(0, 40);
				end
			endcase
			write_reg(REG_DEBOUNCE, CNT_W'(db));
			write_reg(REG_DOUBLE_GAP, CNT_W'(gap));
			write_reg(REG_LONG, CNT_W'(lng));
			sender_calm = ($urandom_range(0, 3) == 0);
			db_c = (db > 60) ? 60 : db;
			gap_c = (gap > 60) ? 60 : gap;
			long_c = (lng > 60) ? 60 : lng;
			level = 1'b1;
			sent = 0;
			while (sent < PHASE_TICKS) begin
				k = $urandom_range(0, 9);
				if (k < 2)
					run_len = $urandom_range(1, db_c + 1);
				else if (k < 6)
					run_len = db_c + 1 + $urandom_range(0, gap_c / 2 + 1);
				else if (k < 8)
					run_len = gap_c + $urandom_range(1, db_c + 4);
				else
					run_len = long_c + $urandom_range(1, 4);
				for (int i = 0; i < run_len && sent < PHASE_TICKS; i++) begin
					// occasional contact bounce against the intended level
					push_tick(level ^ ($urandom_range(0, 15) == 0), 1'b0, EV_NONE);
					sent++;
				end
				level = ~level;
			end
		end

		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("button_press_classifier: match");
		else
			$display("button_press_classifier: mismatch");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/bpc_pkg.sv
rtl/bpc_cfg_regs.sv
rtl/bpc_core.sv
rtl/button_press_classifier.sv
tb/tb_button_press_classifier.sv
